### rtl/core/mpd_pkg.sv
`timescale 1ns / 1ps

package mpd_pkg;

	localparam int DIV_W  = 31;
	localparam int STEP_W = $clog2(DIV_W);
	localparam int VAL_W  = 31;
	localparam int EXP_W  = 16;
	localparam int NEED_W = 21;
	localparam int CNT_W  = 5;
	localparam int TD_W   = 16;
	localparam int SQ_W   = 32;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
		logic [DIV_W-1:0] rem;
	} div_rsp_t;

endpackage

### rtl/core/mpd_div.sv
`timescale 1ns / 1ps

module mpd_div (
	input  logic              clk,
	input  logic              arst_n,
	input  mpd_pkg::div_req_t req,
	output mpd_pkg::div_rsp_t rsp
);
	import mpd_pkg::*;

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  dsr_q;
	logic [DIV_W:0]    shifted;
	logic [DIV_W:0]    diff;
	logic              fits;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign fits    = !diff[DIV_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (req.start && !busy_q) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == LAST_STEP) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule

### rtl/core/min_power_divisibility_core.sv
`timescale 1ns / 1ps

// Least power of a value divisible by target_base ** target_exponent.
// Input channel (value, last_item) and result channel (item_ok, item_power,
// best_ok, best_power, set_done) use valid/stall; a transaction moves when
// valid is high and stall is low. One transaction is worked on at a time:
// value_stall is high from acceptance until the result is loaded into the
// output register, which may still hold the previous result while the next
// item runs. A result waits in the output register while result_stall is high.
// All arithmetic runs on one shared radix-2 divider. Per item: for every table
// prime with a nonzero need, (c + 2) divisions where c is how often the prime
// divides the value; a zero value needs no division, and an item whose value
// misses a prime stops at that prime. Worst case about 35 divisions.
// The first item after reset or after a register write first factors
// target_base by trial division: per candidate divisor up to the square root
// of the remaining cofactor, one division plus one more per factor found, at
// most ~46000 divisions. Reset restores target_base and target_exponent to 1,
// clears the running minimum and forces a new factoring. Registers:
// target_base at 0x0, target_exponent at 0x4; write only while idle.
module min_power_divisibility_core #(
	parameter int MAX_PRIMES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        value_valid,
	output logic        value_stall,
	input  logic [30:0] value,
	input  logic        last_item,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        item_ok,
	output logic [20:0] item_power,
	output logic        best_ok,
	output logic [20:0] best_power,
	output logic        set_done
);
	import mpd_pkg::*;

	localparam int IDX_W = $clog2(MAX_PRIMES);
	localparam int PC_W  = $clog2(MAX_PRIMES + 1);
	localparam logic [PC_W-1:0] PC_MAX = PC_W'(MAX_PRIMES);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_FINIT = 9'b000000010,
		S_FTEST = 9'b000000100,
		S_FDIV  = 9'b000001000,
		S_PINIT = 9'b000010000,
		S_PNEXT = 9'b000100000,
		S_PDIV  = 9'b001000000,
		S_CDIV  = 9'b010000000,
		S_EMIT  = 9'b100000000
	} state_t;

	typedef enum logic {
		REG_BASE = 1'b0,
		REG_EXP  = 1'b1
	} reg_t;

	state_t            state_q;
	logic [VAL_W-1:0]  base_q;
	logic [EXP_W-1:0]  exp_q;
	logic              table_ready_q;
	logic [VAL_W-1:0]  prime_q [MAX_PRIMES];
	logic [NEED_W-1:0] need_q [MAX_PRIMES];
	logic [PC_W-1:0]   pcount_q;
	logic [VAL_W-1:0]  rest_q;
	logic [TD_W-1:0]   d_q;
	logic [SQ_W-1:0]   sq_q;
	logic              mult_q;
	logic [NEED_W-1:0] acc_q;
	logic [VAL_W-1:0]  val_q;
	logic              last_q;
	logic [PC_W-1:0]   k_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [NEED_W-1:0] power_q;
	logic              ok_q;
	logic [NEED_W-1:0] best_q;
	logic              found_q;
	logic              out_valid_q;
	logic              out_ok_q;
	logic [NEED_W-1:0] out_power_q;
	logic              out_best_ok_q;
	logic [NEED_W-1:0] out_best_q;
	logic              out_done_q;

	div_req_t          dreq;
	div_rsp_t          drsp;

	logic              cfg_wr;
	reg_t              cfg_reg;
	logic              in_take;
	logic              out_free;
	logic [IDX_W-1:0]  kidx;
	logic [IDX_W-1:0]  pidx;
	logic              store_en;
	logic [VAL_W-1:0]  store_p;
	logic [NEED_W-1:0] store_n;
	logic [NEED_W:0]   ceil_num;
	logic              upd;
	logic              nfound;
	logic [NEED_W-1:0] nbest;
	logic [NEED_W-1:0] qpow;

	mpd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign cfg_wr   = psel && penable && pwrite && pready;
	assign cfg_reg  = reg_t'(paddr[2]);
	assign pready   = 1'b1;
	assign in_take  = value_valid && !value_stall;
	assign out_free = !out_valid_q || !result_stall;
	assign kidx     = k_q[IDX_W-1:0];
	assign pidx     = pcount_q[IDX_W-1:0];
	assign ceil_num = {1'b0, need_q[kidx]} + (NEED_W+1)'(cnt_q) - 1'b1;
	assign qpow     = drsp.quot[NEED_W-1:0];

	assign upd    = ok_q && (!found_q || power_q < best_q);
	assign nfound = found_q || upd;
	assign nbest  = upd ? power_q : best_q;

	always_comb begin
		unique case (cfg_reg)
			REG_BASE: prdata = {1'b0, base_q};
			REG_EXP:  prdata = {16'd0, exp_q};
			default:  prdata = '0;
		endcase
	end

	always_comb begin
		dreq.start    = 1'b0;
		dreq.dividend = '0;
		dreq.divisor  = '0;
		unique case (state_q)
			S_FTEST: begin
				dreq.start    = sq_q <= {1'b0, rest_q};
				dreq.dividend = rest_q;
				dreq.divisor  = DIV_W'(d_q);
			end
			S_FDIV: begin
				dreq.start    = drsp.done && drsp.rem == '0;
				dreq.dividend = drsp.quot;
				dreq.divisor  = DIV_W'(d_q);
			end
			S_PNEXT: begin
				dreq.start    = k_q != pcount_q && need_q[kidx] != '0 && val_q != '0;
				dreq.dividend = val_q;
				dreq.divisor  = prime_q[kidx];
			end
			S_PDIV: begin
				if (drsp.rem == '0) begin
					dreq.start    = drsp.done;
					dreq.dividend = drsp.quot;
					dreq.divisor  = prime_q[kidx];
				end else begin
					dreq.start    = drsp.done && cnt_q != '0;
					dreq.dividend = DIV_W'(ceil_num);
					dreq.divisor  = DIV_W'(cnt_q);
				end
			end
			default: begin
				dreq.start = 1'b0;
			end
		endcase
	end

	always_comb begin
		store_en = 1'b0;
		store_p  = rest_q;
		store_n  = NEED_W'(exp_q);
		if (state_q == S_FTEST && sq_q > {1'b0, rest_q} && rest_q != VAL_W'(1)) begin
			store_en = 1'b1;
		end else if (state_q == S_FDIV && drsp.done && drsp.rem != '0 && mult_q) begin
			store_en = 1'b1;
			store_p  = VAL_W'(d_q);
			store_n  = acc_q;
		end
		store_en = store_en && pcount_q < PC_MAX;
	end

	always_ff @(posedge clk) begin
		if (store_en) begin
			prime_q[pidx] <= store_p;
			need_q[pidx]  <= store_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			base_q        <= VAL_W'(1);
			exp_q         <= EXP_W'(1);
			table_ready_q <= 1'b0;
			pcount_q      <= '0;
			found_q       <= 1'b0;
			best_q        <= '0;
			out_valid_q   <= 1'b0;
			k_q           <= '0;
			cnt_q         <= '0;
			mult_q        <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_reg)
					REG_BASE: base_q <= pwdata[VAL_W-1:0];
					REG_EXP:  exp_q  <= pwdata[EXP_W-1:0];
					default:  base_q <= base_q;
				endcase
				table_ready_q <= 1'b0;
			end
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			if (store_en) begin
				pcount_q <= pcount_q + 1'b1;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						state_q <= table_ready_q ? S_PINIT : S_FINIT;
					end
				end
				S_FINIT: begin
					pcount_q <= '0;
					mult_q   <= 1'b0;
					state_q  <= S_FTEST;
				end
				S_FTEST: begin
					if (sq_q <= {1'b0, rest_q}) begin
						state_q <= S_FDIV;
					end else begin
						table_ready_q <= 1'b1;
						state_q       <= S_PINIT;
					end
				end
				S_FDIV: begin
					if (drsp.done) begin
						if (drsp.rem == '0) begin
							mult_q <= 1'b1;
						end else begin
							mult_q  <= 1'b0;
							state_q <= S_FTEST;
						end
					end
				end
				S_PINIT: begin
					k_q     <= '0;
					state_q <= S_PNEXT;
				end
				S_PNEXT: begin
					cnt_q <= '0;
					if (k_q == pcount_q) begin
						state_q <= S_EMIT;
					end else if (need_q[kidx] == '0 || val_q == '0) begin
						k_q <= k_q + 1'b1;
					end else begin
						state_q <= S_PDIV;
					end
				end
				S_PDIV: begin
					if (drsp.done) begin
						if (drsp.rem == '0) begin
							cnt_q <= cnt_q + 1'b1;
						end else if (cnt_q == '0) begin
							state_q <= S_EMIT;
						end else begin
							state_q <= S_CDIV;
						end
					end
				end
				S_CDIV: begin
					if (drsp.done) begin
						k_q     <= k_q + 1'b1;
						state_q <= S_PNEXT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						found_q <= last_q ? 1'b0 : nfound;
						best_q  <= last_q ? '0 : nbest;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			val_q  <= value;
			last_q <= last_item;
		end
		unique case (state_q)
			S_FINIT: begin
				rest_q <= (base_q == '0) ? VAL_W'(1) : base_q;
				d_q    <= TD_W'(2);
				sq_q   <= SQ_W'(4);
				acc_q  <= '0;
			end
			S_FDIV: begin
				if (drsp.done) begin
					if (drsp.rem == '0) begin
						rest_q <= drsp.quot;
						acc_q  <= acc_q + NEED_W'(exp_q);
					end else begin
						d_q   <= d_q + 1'b1;
						sq_q  <= sq_q + SQ_W'({d_q, 1'b1});
						acc_q <= '0;
					end
				end
			end
			S_PINIT: begin
				power_q <= '0;
				ok_q    <= 1'b1;
			end
			S_PNEXT: begin
				if (k_q != pcount_q && need_q[kidx] != '0 && val_q == '0
					&& power_q < NEED_W'(1)) begin
					power_q <= NEED_W'(1);
				end
			end
			S_PDIV: begin
				if (drsp.done && drsp.rem != '0 && cnt_q == '0) begin
					ok_q <= 1'b0;
				end
			end
			S_CDIV: begin
				if (drsp.done && qpow > power_q) begin
					power_q <= qpow;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					out_ok_q      <= ok_q;
					out_power_q   <= ok_q ? power_q : '0;
					out_best_ok_q <= nfound;
					out_best_q    <= nfound ? nbest : '0;
					out_done_q    <= last_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign value_stall  = state_q != S_IDLE;
	assign result_valid = out_valid_q;
	assign item_ok      = out_ok_q;
	assign item_power   = out_power_q;
	assign best_ok      = out_best_ok_q;
	assign best_power   = out_best_q;
	assign set_done     = out_done_q;

	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == S_EMIT))
		else $error("result appeared without a finished computation");

	a_item_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !item_ok |-> item_power == '0)
		else $error("item_power set on a value without answer");

	a_best_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && item_ok |-> best_ok && best_power <= item_power)
		else $error("running minimum exceeds the item answer");

	a_best_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !best_ok |-> best_power == '0)
		else $error("best_power set while no answer in set");

endmodule

### tb/tb_min_power_divisibility_core.sv
`timescale 1ns / 1ps

module tb_min_power_divisibility_core;
	import mpd_pkg::*;

	localparam int TABLE_DEPTH = 16;
	localparam logic [VAL_W-1:0] VALUE_MAX = '1;
	localparam longint unsigned VALUE_LIMIT = 64'h7FFF_FFFF;
	localparam int RANDOM_PHASES = 12;
	localparam int ITEMS_PER_PHASE = 132;
	localparam int WATCHDOG_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 2000;
	localparam int HOLD_CYCLES = 4000;
	localparam int HOLD_AFTER = 500;

	typedef enum int {
		REG_TARGET_BASE     = 0,
		REG_TARGET_EXPONENT = 1
	} reg_index_e;

	typedef struct packed {
		logic              item_ok;
		logic [NEED_W-1:0] item_power;
		logic              best_ok;
		logic [NEED_W-1:0] best_power;
		logic              set_done;
	} answer_t;

	class power_ledger;
		logic [VAL_W-1:0]  base_reg;
		logic [EXP_W-1:0]  exp_reg;
		logic [VAL_W-1:0]  primes [TABLE_DEPTH];
		logic [NEED_W-1:0] needs [TABLE_DEPTH];
		int unsigned       prime_total;
		bit                table_built;
		logic [NEED_W-1:0] set_best;
		bit                set_found;
		answer_t           pending [$];
		int unsigned       fail_count;

		function new();
			base_reg = 1;
			exp_reg = 1;
			prime_total = 0;
			table_built = 0;
			set_best = 0;
			set_found = 0;
			fail_count = 0;
		endfunction

		function void note_register(reg_index_e idx, logic [31:0] data);
			if (idx == REG_TARGET_BASE) begin
				base_reg = data[VAL_W-1:0];
				table_built = 0;
			end else if (idx == REG_TARGET_EXPONENT) begin
				exp_reg = data[EXP_W-1:0];
				table_built = 0;
			end
		endfunction

		function void add_prime(longint unsigned p, int unsigned mult);
			if (prime_total < TABLE_DEPTH) begin
				primes[prime_total] = p[VAL_W-1:0];
				needs[prime_total] = NEED_W'(mult * exp_reg);
				prime_total++;
			end
		endfunction

		function void factor_base();
			longint unsigned rest;
			longint unsigned d;
			int unsigned mult;
			prime_total = 0;
			rest = base_reg;
			if (rest == 0)
				rest = 1;
			for (d = 2; d * d <= rest; d++) begin
				mult = 0;
				while (rest % d == 0) begin
					rest = rest / d;
					mult++;
				end
				if (mult != 0)
					add_prime(d, mult);
			end
			if (rest != 1)
				add_prime(rest, 1);
			table_built = 1;
		endfunction

		function void note_value(logic [VAL_W-1:0] v, logic last);
			bit ok;
			int unsigned power;
			int unsigned cnt;
			int unsigned q;
			logic [VAL_W-1:0] r;
			answer_t want;
			ok = 1;
			power = 0;
			if (!table_built)
				factor_base();
			for (int k = 0; k < prime_total; k++) begin
				if (needs[k] == 0)
					continue;
				if (v == 0) begin
					q = 1;
				end else begin
					cnt = 0;
					r = v;
					while (primes[k] >= 2 && r % primes[k] == 0) begin
						r = r / primes[k];
						cnt++;
					end
					if (cnt == 0) begin
						ok = 0;
						break;
					end
					q = (needs[k] + cnt - 1) / cnt;
				end
				if (q > power)
					power = q;
			end
			if (!ok)
				power = 0;
			if (ok && (!set_found || power < set_best)) begin
				set_best = NEED_W'(power);
				set_found = 1;
			end
			want.item_ok = ok;
			want.item_power = NEED_W'(power);
			want.best_ok = set_found;
			want.best_power = set_found ? set_best : '0;
			want.set_done = last;
			pending.push_back(want);
			if (last) begin
				set_found = 0;
				set_best = 0;
			end
		endfunction

		function void check_answer(logic ok, logic [NEED_W-1:0] power, logic bok,
				logic [NEED_W-1:0] bpower, logic done);
			answer_t want;
			if (pending.size() == 0) begin
				$error("result transaction with no answer pending");
				fail_count++;
				return;
			end
			want = pending.pop_front();
			if (ok !== want.item_ok) begin
				$error("item_ok expected %0d got %0d", want.item_ok, ok);
				fail_count++;
			end
			if (power !== want.item_power) begin
				$error("item_power expected %0d got %0d", want.item_power, power);
				fail_count++;
			end
			if (bok !== want.best_ok) begin
				$error("best_ok expected %0d got %0d", want.best_ok, bok);
				fail_count++;
			end
			if (bpower !== want.best_power) begin
				$error("best_power expected %0d got %0d", want.best_power, bpower);
				fail_count++;
			end
			if (done !== want.set_done) begin
				$error("set_done expected %0d got %0d", want.set_done, done);
				fail_count++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        value_valid;
	logic        value_stall;
	logic [30:0] value;
	logic        last_item;
	logic        result_valid;
	logic        result_stall;
	logic        item_ok;
	logic [20:0] item_power;
	logic        best_ok;
	logic [20:0] best_power;
	logic        set_done;

	power_ledger ledger;
	int send_idle_pct;
	int recv_idle_pct;
	int answers_seen;
	int quiet_cycles;
	int unsigned target_primes [$];
	int unsigned prime_pool [0:19] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29,
		31, 37, 41, 43, 47, 53, 61, 97, 251, 1021};

	min_power_divisibility_core #(
		.MAX_PRIMES(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.value_valid(value_valid),
		.value_stall(value_stall),
		.value(value),
		.last_item(last_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.item_ok(item_ok),
		.item_power(item_power),
		.best_ok(best_ok),
		.best_power(best_power),
		.set_done(set_done)
	);

	initial clk = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic write_reg(reg_index_e idx, logic [31:0] data);
		logic [31:0] readback;
		readback = (idx == REG_TARGET_BASE) ? {1'b0, data[VAL_W-1:0]} :
			{16'b0, data[EXP_W-1:0]};
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(4 * idx);
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		ledger.note_register(idx, data);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== readback) begin
			$error("prdata expected %0h got %0h", readback, prdata);
			ledger.fail_count++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send_value(logic [VAL_W-1:0] v, logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			value_valid <= 1'b0;
			@(negedge clk);
		end
		value <= v;
		last_item <= last;
		value_valid <= 1'b1;
		do @(posedge clk); while (value_stall);
		ledger.note_value(v, last);
		@(negedge clk);
	endtask

	task automatic finish_phase();
		value_valid <= 1'b0;
		while (ledger.pending.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [VAL_W-1:0] pick_target();
		longint unsigned prod;
		int unsigned p;
		int unsigned m;
		int unsigned idx;
		bit taken [0:19];
		prod = 1;
		target_primes.delete();
		foreach (taken[i])
			taken[i] = 1'b0;
		repeat ($urandom_range(1, 5)) begin
			idx = $urandom_range(0, 19);
			p = prime_pool[idx];
			if (!taken[idx] && prod * p <= VALUE_LIMIT) begin
				taken[idx] = 1'b1;
				target_primes.push_back(p);
				prod = prod * p;
				m = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : $urandom_range(0, 2);
				repeat (m)
					if (prod * p <= VALUE_LIMIT)
						prod = prod * p;
			end
		end
		return prod[VAL_W-1:0];
	endfunction

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			ledger.check_answer(item_ok, item_power, best_ok, best_power, set_done);
			answers_seen++;
		end
	end

	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else if (!hold_done && answers_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (value_valid && !value_stall) || (result_valid && !result_stall) ||
				(psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [VAL_W-1:0] base;
		logic [EXP_W-1:0] expo;
		longint unsigned val;
		int unsigned p;
		int unsigned kind;
		ledger = new();
		answers_seen = 0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		value_valid = 1'b0;
		value = '0;
		last_item = 1'b0;
		arst_n = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings give an empty table
		send_value('0, 1'b0);
		send_value(VALUE_MAX, 1'b0);
		send_value(31'd1, 1'b1);
		finish_phase();

		// base zero behaves as base one
		write_reg(REG_TARGET_BASE, 32'd0);
		write_reg(REG_TARGET_EXPONENT, 32'd5);
		send_value(31'd12, 1'b1);
		finish_phase();

		// exponent zero ignores every prime
		write_reg(REG_TARGET_BASE, 32'd12);
		write_reg(REG_TARGET_EXPONENT, 32'd0);
		send_value(31'd7, 1'b0);
		send_value(31'd12, 1'b1);
		finish_phase();

		write_reg(REG_TARGET_BASE, 32'd2147483646);
		write_reg(REG_TARGET_EXPONENT, 32'd65535);
		send_value(31'd2147483646, 1'b0);
		send_value('0, 1'b0);
		send_value(31'd3, 1'b0);
		send_value(31'd1, 1'b1);
		finish_phase();

		write_reg(REG_TARGET_BASE, 32'h4000_0000);
		send_value(31'd2, 1'b0);
		send_value(31'h4000_0000, 1'b0);
		send_value(VALUE_MAX, 1'b1);
		finish_phase();

		write_reg(REG_TARGET_BASE, 32'd6);
		write_reg(REG_TARGET_EXPONENT, 32'd1);
		send_value(31'd6, 1'b0);
		send_value(31'd9, 1'b0);
		send_value(31'd36, 1'b1);
		finish_phase();

		// exponent alone must force a new factoring
		write_reg(REG_TARGET_EXPONENT, 32'd3);
		send_value(31'd6, 1'b1);
		finish_phase();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph / 4)
				0: begin
					send_idle_pct = 32;
					recv_idle_pct = 74;
				end
				1: begin
					send_idle_pct = 74;
					recv_idle_pct = 32;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			base = pick_target();
			if (ph == 0)
				expo = 16'd65535;
			else if (ph == 1)
				expo = 16'd1;
			else if ($urandom_range(0, 2) == 0)
				expo = EXP_W'($urandom_range(1, 65535));
			else
				expo = EXP_W'($urandom_range(1, 40));
			write_reg(REG_TARGET_BASE, {1'b0, base});
			write_reg(REG_TARGET_EXPONENT, {16'b0, expo});
			repeat (ITEMS_PER_PHASE) begin
				kind = $urandom_range(0, 9);
				if (kind < 7) begin
					val = 1;
					foreach (target_primes[i])
						val = val * target_primes[i];
					foreach (target_primes[i])
						repeat ($urandom_range(0, 8))
							if (val * target_primes[i] <= VALUE_LIMIT)
								val = val * target_primes[i];
					if ($urandom_range(0, 1) == 0) begin
						val = val * $urandom_range(1, 32'(VALUE_LIMIT / val));
					end else begin
						p = $urandom_range(1, 50);
						if (val * p <= VALUE_LIMIT)
							val = val * p;
					end
					if (kind == 6) begin
						p = target_primes[$urandom_range(0, target_primes.size() - 1)];
						while (val % p == 0)
							val = val / p;
					end
				end else if (kind < 9) begin
					val = $urandom & VALUE_LIMIT;
				end else begin
					case ($urandom_range(0, 3))
						0: val = 0;
						1: val = VALUE_LIMIT;
						default: val = 64'd1 << $urandom_range(0, 30);
					endcase
				end
				send_value(val[VAL_W-1:0], $urandom_range(0, 4) == 0);
			end
			finish_phase();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (ledger.fail_count == 0 && ledger.pending.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
